// ----- src/clvq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package clvq_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned WINNER_W = 4;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [ACTION_W-1:0] ACT_TRAIN = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLASSIFY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_HALVE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_RATE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_WEIGHT = 1'd1;

    localparam logic [DATA_W-1:0] RATE_RESET = 16'd39322;
    localparam logic [DATA_W-1:0] WEIGHT_RESET = 16'd32768;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   feature_a;
        logic [DATA_W-1:0]   feature_b;
    } in_word_t;

    typedef struct packed {
        logic [WINNER_W-1:0] winner;
        logic [DATA_W-1:0]   weight_a;
        logic [DATA_W-1:0]   weight_b;
        logic [DATA_W-1:0]   rate_now;
    } out_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } weight_pair_t;

    typedef struct packed {
        logic              wr_en;
        logic              clear;
        logic [DATA_W-1:0] fill;
        weight_pair_t      wr_data;
    } wmem_ctl_t;

    function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] p,
                                                   input logic [DATA_W-1:0] q);
        logic [DATA_W-1:0] d;
        if (p >= q)
        begin
            d = p - q;
        end
        else
        begin
            d = q - p;
        end
        return d;
    endfunction

    // Rounds rate times distance back to Q0.16 and moves the weight toward the sample.
    function automatic logic [DATA_W-1:0] move_weight(input logic [DATA_W-1:0] w,
                                                      input logic [DATA_W-1:0] x,
                                                      input logic [2*DATA_W-1:0] prod);
        logic [2*DATA_W:0] rounded;
        logic [DATA_W:0]   delta;
        logic [DATA_W+1:0] sum;
        logic [DATA_W-1:0] res;
        rounded = {1'b0, prod} + (2*DATA_W+1)'(32768);
        delta = rounded[2*DATA_W:DATA_W];
        sum = {2'b00, w} + {1'b0, delta};
        if (x >= w)
        begin
            if (sum[DATA_W+1:DATA_W] != 2'b00)
            begin
                res = '1;
            end
            else
            begin
                res = sum[DATA_W-1:0];
            end
        end
        else
        begin
            if (delta > {1'b0, w})
            begin
                res = '0;
            end
            else
            begin
                res = w - delta[DATA_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/clvq_wmem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clvq_wmem
    import clvq_pkg::*;
#(
    parameter int unsigned DEPTH = 2,
    parameter int unsigned AW = 1
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire wmem_ctl_t    ctl,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [AW-1:0] rd_addr,
    output weight_pair_t      rd_data
);

    weight_pair_t      mem_reg [DEPTH];
    weight_pair_t      rdata_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic              rvalid_reg;
    logic [DATA_W-1:0] fill_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[wr_addr] <= ctl.wr_data;
        end
        rdata_reg <= mem_reg[rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = '0;
        end
        else if (ctl.wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rvalid_reg <= 1'b0;
            fill_reg <= WEIGHT_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            rvalid_reg <= valid_reg[rd_addr];
            if (ctl.clear)
            begin
                fill_reg <= ctl.fill;
            end
        end
    end

    // An entry not written since the last restart reads as the restart weight.
    assign rd_data = rvalid_reg ? rdata_reg : weight_pair_t'{a: fill_reg, b: fill_reg};

endmodule

`default_nettype wire

// ----- src/competitive_learning_vector_quantizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Train searches every neuron, then updates the winner's weights; classify only searches.
// End of epoch checks only neuron 0 and restart skips the search; one word is in work at a time.
// Each neuron takes four steps: weight memory read, two squares on the shared multiplier, compare.
// The next word can be accepted in the cycle after a result is handed to the output register.
// Reset loads the rate to 0.6 and every weight to 0.5 at once; no clearing pass is needed.

module competitive_learning_vector_quantizer
    import clvq_pkg::*;
#(
    parameter int unsigned NEURONS = 2
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_word_t               in_word,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_word_t                   out_word,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]      cfg_data
);

    localparam int unsigned IDX_W = $clog2(NEURONS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NEURONS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD = 4'd1;
    localparam logic [3:0] S_SQA = 4'd2;
    localparam logic [3:0] S_SQB = 4'd3;
    localparam logic [3:0] S_CMP = 4'd4;
    localparam logic [3:0] S_UPA = 4'd5;
    localparam logic [3:0] S_UPB = 4'd6;
    localparam logic [3:0] S_WR = 4'd7;
    localparam logic [3:0] S_FIN = 4'd8;

    logic [3:0]          state_reg;
    logic [DATA_W-1:0]   init_rate_reg;
    logic [DATA_W-1:0]   init_weight_reg;
    logic [DATA_W-1:0]   rate_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [DATA_W-1:0]   fa_reg;
    logic [DATA_W-1:0]   fb_reg;
    logic [IDX_W-1:0]    n_reg;
    logic [DATA_W-1:0]   w_a_reg;
    logic [DATA_W-1:0]   w_b_reg;
    logic [2*DATA_W-1:0] prod_reg;
    logic [2*DATA_W-1:0] hold_reg;
    logic [2*DATA_W:0]   best_dist_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [DATA_W-1:0]   best_wa_reg;
    logic [DATA_W-1:0]   best_wb_reg;
    logic [DATA_W-1:0]   new_a_reg;
    logic                out_valid_reg;
    out_word_t           out_reg;

    logic                in_accept;
    logic                out_free;
    logic [DATA_W-1:0]   mul_x;
    logic [DATA_W-1:0]   mul_y;
    logic [2*DATA_W-1:0] mul_p;
    logic [2*DATA_W:0]   dist_sum;
    logic [DATA_W-1:0]   new_b;
    logic [DATA_W-1:0]   da;
    wmem_ctl_t           wctl;
    weight_pair_t        rd_data;

    assign in_stall = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_word = out_reg;

    assign da = abs_diff(rd_data.a, fa_reg);
    assign dist_sum = {1'b0, hold_reg} + {1'b0, prod_reg};
    assign new_b = move_weight(best_wb_reg, fb_reg, prod_reg);

    always_comb
    begin
        case (state_reg)
            S_SQA:
            begin
                mul_x = da;
                mul_y = da;
            end
            S_SQB:
            begin
                mul_x = abs_diff(w_b_reg, fb_reg);
                mul_y = abs_diff(w_b_reg, fb_reg);
            end
            S_UPA:
            begin
                mul_x = rate_reg;
                mul_y = abs_diff(best_wa_reg, fa_reg);
            end
            S_UPB:
            begin
                mul_x = rate_reg;
                mul_y = abs_diff(best_wb_reg, fb_reg);
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    always_comb
    begin
        wctl.wr_en = (state_reg == S_WR);
        wctl.clear = in_accept && (in_word.action == ACT_RESTART);
        wctl.fill = init_weight_reg;
        wctl.wr_data = '{a: new_a_reg, b: new_b};
    end

    clvq_wmem #(
        .DEPTH(NEURONS),
        .AW(IDX_W)
    ) u_wmem (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(wctl),
        .wr_addr(best_idx_reg),
        .rd_addr(n_reg),
        .rd_data(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_rate_reg <= RATE_RESET;
            init_weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INITIAL_RATE:   init_rate_reg <= cfg_data;
                REG_INITIAL_WEIGHT: init_weight_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rate_reg <= RATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        case (in_word.action)
                            ACT_HALVE:
                            begin
                                rate_reg <= rate_reg >> 1;
                                state_reg <= S_RD;
                            end
                            ACT_RESTART:
                            begin
                                rate_reg <= init_rate_reg;
                                state_reg <= S_FIN;
                            end
                            default:
                            begin
                                state_reg <= S_RD;
                            end
                        endcase
                    end
                end
                S_RD:  state_reg <= S_SQA;
                S_SQA: state_reg <= S_SQB;
                S_SQB: state_reg <= S_CMP;
                S_CMP:
                begin
                    if (action_reg == ACT_HALVE || n_reg == LAST_IDX)
                    begin
                        state_reg <= (action_reg == ACT_TRAIN) ? S_UPA : S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_UPA: state_reg <= S_UPB;
                S_UPB: state_reg <= S_WR;
                S_WR:  state_reg <= S_FIN;
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    action_reg <= in_word.action;
                    fa_reg <= in_word.feature_a;
                    fb_reg <= in_word.feature_b;
                    n_reg <= '0;
                    best_idx_reg <= '0;
                    best_wa_reg <= init_weight_reg;
                    best_wb_reg <= init_weight_reg;
                end
            end
            S_SQA:
            begin
                w_a_reg <= rd_data.a;
                w_b_reg <= rd_data.b;
            end
            S_SQB:
            begin
                hold_reg <= prod_reg;
            end
            S_CMP:
            begin
                // Ties go to the later neuron.
                if (n_reg == '0 || dist_sum <= best_dist_reg)
                begin
                    best_dist_reg <= dist_sum;
                    best_idx_reg <= n_reg;
                    best_wa_reg <= w_a_reg;
                    best_wb_reg <= w_b_reg;
                end
                n_reg <= n_reg + IDX_W'(1);
            end
            S_UPB:
            begin
                new_a_reg <= move_weight(best_wa_reg, fa_reg, prod_reg);
            end
            S_WR:
            begin
                best_wa_reg <= new_a_reg;
                best_wb_reg <= new_b;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_reg.winner <= WINNER_W'(best_idx_reg);
                    out_reg.weight_a <= best_wa_reg;
                    out_reg.weight_b <= best_wb_reg;
                    out_reg.rate_now <= rate_reg;
                end
            end
            default: ;
        endcase
    end

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result word raised outside the finish step");

    a_winner_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> {1'b0, out_reg.winner} < (WINNER_W+1)'(NEURONS))
        else $error("winner index beyond the neuron count");

    a_restart_short: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_word.action == ACT_RESTART) |=> state_reg == S_FIN)
        else $error("restart did not go straight to the result");

    a_rate_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> rate_reg == $past(rate_reg))
        else $error("learning rate changed while a word was in work");

endmodule

`default_nettype wire

// ----- dv/competitive_learning_vector_quantizer_tb.sv -----
`timescale 1ns / 1ps

module competitive_learning_vector_quantizer_tb;
    import clvq_pkg::*;

    localparam int unsigned NEURONS = 2;
    localparam int unsigned IDLE_PERCENT = 31;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned PHASES = 6;
    localparam int unsigned WORDS_PER_PHASE = 150;

    class clvq_scoreboard;
        logic [DATA_W-1:0] proto_a [NEURONS];
        logic [DATA_W-1:0] proto_b [NEURONS];
        logic [DATA_W-1:0] rate;
        logic [DATA_W-1:0] start_rate;
        logic [DATA_W-1:0] start_weight;
        out_word_t         pending_results [$];
        int                errors;

        function new();
            start_rate = RATE_RESET;
            start_weight = WEIGHT_RESET;
            errors = 0;
            reload();
        endfunction

        function void reload();
            for (int n = 0; n < NEURONS; n++)
            begin
                proto_a[n] = start_weight;
                proto_b[n] = start_weight;
            end
            rate = start_rate;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_INITIAL_RATE: start_rate = val;
                REG_INITIAL_WEIGHT: start_weight = val;
                default: ;
            endcase
        endfunction

        function longint unsigned distance(int n, logic [DATA_W-1:0] fa,
                                           logic [DATA_W-1:0] fb);
            longint unsigned da;
            longint unsigned db;
            da = (proto_a[n] > fa) ? proto_a[n] - fa : fa - proto_a[n];
            db = (proto_b[n] > fb) ? proto_b[n] - fb : fb - proto_b[n];
            return da * da + db * db;
        endfunction

        function logic [DATA_W-1:0] step_toward(logic [DATA_W-1:0] w, logic [DATA_W-1:0] x);
            longint unsigned mag;
            longint unsigned delta;
            longint          moved;
            mag = (x >= w) ? x - w : w - x;
            delta = (64'(rate) * mag + 64'd32768) >> 16;
            if (x >= w)
            begin
                moved = longint'(w) + longint'(delta);
            end
            else
            begin
                moved = longint'(w) - longint'(delta);
            end
            if (moved < 0)
            begin
                moved = 0;
            end
            if (moved > 65535)
            begin
                moved = 65535;
            end
            return DATA_W'(moved);
        endfunction

        function void note_sample(in_word_t w);
            out_word_t       res;
            int              win;
            longint unsigned best;
            longint unsigned d;
            win = 0;
            case (w.action)
                ACT_TRAIN, ACT_CLASSIFY:
                begin
                    best = distance(0, w.feature_a, w.feature_b);
                    for (int n = 1; n < NEURONS; n++)
                    begin
                        d = distance(n, w.feature_a, w.feature_b);
                        if (d <= best)
                        begin
                            best = d;
                            win = n;
                        end
                    end
                    if (w.action == ACT_TRAIN)
                    begin
                        proto_a[win] = step_toward(proto_a[win], w.feature_a);
                        proto_b[win] = step_toward(proto_b[win], w.feature_b);
                    end
                end
                ACT_HALVE: rate = rate >> 1;
                default: reload();
            endcase
            res.winner = WINNER_W'(win);
            res.weight_a = proto_a[win];
            res.weight_b = proto_b[win];
            res.rate_now = rate;
            pending_results.push_back(res);
        endfunction

        function void compare_field(string field, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("winner", DATA_W'(want.winner), DATA_W'(got.winner));
            compare_field("weight_a", want.weight_a, got.weight_a);
            compare_field("weight_b", want.weight_b, got.weight_b);
            compare_field("rate_now", want.rate_now, got.rate_now);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_word_t               in_word = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_word_t              out_word;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data = '0;
    bit                     calm = 1'b0;
    clvq_scoreboard         sb;

    competitive_learning_vector_quantizer #(
        .NEURONS(NEURONS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word(out_word),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(out_word);
        end
    end

    function automatic in_word_t make_word(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] fa,
                                           logic [DATA_W-1:0] fb);
        in_word_t w;
        w.action = act;
        w.feature_a = fa;
        w.feature_b = fb;
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] pick_feature();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return DATA_W'($urandom_range(255));
            3: return DATA_W'(65535 - $urandom_range(255));
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic in_word_t random_word();
        int unsigned roll;
        logic [ACTION_W-1:0] act;
        roll = $urandom_range(99);
        if (roll < 55)
        begin
            act = ACT_TRAIN;
        end
        else if (roll < 90)
        begin
            act = ACT_CLASSIFY;
        end
        else if (roll < 97)
        begin
            act = ACT_HALVE;
        end
        else
        begin
            act = ACT_RESTART;
        end
        return make_word(act, pick_feature(), pick_feature());
    endfunction

    task automatic send_word(in_word_t w);
        if (!calm)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_sample(w);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic [DATA_W-1:0] rate_val, logic [DATA_W-1:0] weight_val);
        cfg_we <= 1'b1;
        cfg_index <= REG_INITIAL_RATE;
        cfg_data <= rate_val;
        @(posedge clk);
        sb.write_reg(REG_INITIAL_RATE, rate_val);
        cfg_index <= REG_INITIAL_WEIGHT;
        cfg_data <= weight_val;
        @(posedge clk);
        sb.write_reg(REG_INITIAL_WEIGHT, weight_val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("competitive_learning_vector_quantizer regression: fail");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all prototypes equal, every distance ties and the last neuron wins.
        send_word(make_word(ACT_CLASSIFY, 16'h0000, 16'h0000));
        send_word(make_word(ACT_TRAIN, 16'hFFFF, 16'hFFFF));
        send_word(make_word(ACT_TRAIN, 16'h0000, 16'h0000));
        send_word(make_word(ACT_CLASSIFY, 16'hFFFF, 16'h0000));
        send_word(make_word(ACT_CLASSIFY, 16'h0000, 16'hFFFF));
        send_word(make_word(ACT_TRAIN, 16'hFFFF, 16'h0000));
        send_word(make_word(ACT_HALVE, 16'hFFFF, 16'hFFFF));
        send_word(make_word(ACT_TRAIN, 16'h0000, 16'hFFFF));
        send_word(make_word(ACT_HALVE, 16'h0000, 16'h0000));
        send_word(make_word(ACT_RESTART, 16'h5555, 16'hAAAA));
        send_word(make_word(ACT_CLASSIFY, 16'd12345, 16'd54321));

        wait_idle();
        write_config(16'hFFFF, 16'h0000);
        send_word(make_word(ACT_RESTART, 16'hAAAA, 16'h5555));
        send_word(make_word(ACT_TRAIN, 16'hFFFF, 16'hFFFF));
        send_word(make_word(ACT_TRAIN, 16'hFFFF, 16'hFFFF));
        send_word(make_word(ACT_TRAIN, 16'h0000, 16'h0000));
        send_word(make_word(ACT_CLASSIFY, 16'h8000, 16'h8000));
        send_word(make_word(ACT_HALVE, 16'h0000, 16'h0000));
        send_word(make_word(ACT_TRAIN, 16'h0001, 16'hFFFE));

        // A zero rate must leave the winner where it is.
        wait_idle();
        write_config(16'h0000, 16'hFFFF);
        send_word(make_word(ACT_RESTART, 16'h0000, 16'h0000));
        send_word(make_word(ACT_TRAIN, 16'h0000, 16'h0000));
        send_word(make_word(ACT_CLASSIFY, 16'h0000, 16'h0000));
        send_word(make_word(ACT_HALVE, 16'hFFFF, 16'hFFFF));
        send_word(make_word(ACT_TRAIN, 16'hFFFF, 16'hFFFF));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: write_config(16'hFFFF, 16'h0000);
                1: write_config(16'h0000, 16'hFFFF);
                4: write_config(RATE_RESET, WEIGHT_RESET);
                default: write_config(DATA_W'($urandom), DATA_W'($urandom));
            endcase
            calm = (p == 3);
            send_word(make_word(ACT_RESTART, DATA_W'($urandom), DATA_W'($urandom)));
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                if (p == 2 && i == WORDS_PER_PHASE / 2)
                begin
                    wait_idle();
                end
                send_word(random_word());
            end
        end
        calm = 1'b0;

        wait_idle();
        if (sb.errors == 0)
        begin
            $display("competitive_learning_vector_quantizer regression: pass");
        end
        else
        begin
            $display("competitive_learning_vector_quantizer regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/clvq_pkg.sv
src/clvq_wmem.sv
src/competitive_learning_vector_quantizer.sv
dv/competitive_learning_vector_quantizer_tb.sv
